/* src/ssd_pkg.sv */
// Package: shared constants, result type and width helper for the SLIP stream decoder.
`default_nettype none
package ssd_pkg;

  localparam int LineByteW     = 8;
  localparam int FrameLenW     = 9;
  localparam int MaxFrameBytesDef = 256;
  localparam logic [FrameLenW-1:0] MinFrameBytesRst = 9'd2;

  localparam logic [LineByteW-1:0] SymEnd    = 8'hC0;
  localparam logic [LineByteW-1:0] SymEsc    = 8'hDB;
  localparam logic [LineByteW-1:0] SymEscEnd = 8'hDC;
  localparam logic [LineByteW-1:0] SymEscEsc = 8'hDD;

  typedef struct packed {
    logic                 data_valid;
    logic [LineByteW-1:0] data_byte;
    logic                 frame_end;
    logic                 frame_abort;
    logic [FrameLenW-1:0] frame_length;
  } ssd_result_t;

  // Counter width: holds the buffer size and never narrower than the length field.
  function automatic int cnt_width(input int max_bytes);
    int w;
    w = $clog2(max_bytes + 1);
    return (w > FrameLenW) ? w : FrameLenW;
  endfunction

endpackage
`default_nettype wire

/* src/ssd_stage.sv */
// Module: one valid/stall register stage holding a payload word.
`default_nettype none
module ssd_stage #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q, valid_d;
  logic [Width-1:0] data_q;
  logic             accept;

  assign stall_o = valid_q & stall_i;
  assign accept  = valid_i & ~stall_o;
  assign valid_d = (valid_q & stall_i) | accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

/* src/ssd_step.sv */
// Module: combinational SLIP decode step, next state and result for one line byte.
`default_nettype none
module ssd_step #(
  parameter int MAX_FRAME_BYTES = ssd_pkg::MaxFrameBytesDef,
  parameter int CntW            = ssd_pkg::cnt_width(ssd_pkg::MaxFrameBytesDef)
) (
  input  logic [ssd_pkg::LineByteW-1:0] line_byte_i,
  input  logic [ssd_pkg::FrameLenW-1:0] min_frame_bytes_i,
  input  logic                          in_frame_i,
  input  logic                          esc_pending_i,
  input  logic [CntW-1:0]               byte_count_i,
  output logic                          in_frame_o,
  output logic                          esc_pending_o,
  output logic [CntW-1:0]               byte_count_o,
  output ssd_pkg::ssd_result_t          result_o
);
  import ssd_pkg::*;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_FRAME_BYTES);

  logic                 do_emit;
  logic [LineByteW-1:0] emit_byte;
  logic [CntW-1:0]      cnt_inc;

  assign cnt_inc = byte_count_i + CntW'(1);

  always_comb begin
    in_frame_o    = in_frame_i;
    esc_pending_o = esc_pending_i;
    byte_count_o  = byte_count_i;
    result_o      = '0;
    do_emit       = 1'b0;
    emit_byte     = line_byte_i;

    if (!in_frame_i) begin
      if (line_byte_i == SymEnd) begin
        in_frame_o    = 1'b1;
        esc_pending_o = 1'b0;
        byte_count_o  = '0;
      end
    end else if (esc_pending_i) begin
      esc_pending_o = 1'b0;
      if (line_byte_i == SymEscEsc) begin
        do_emit   = 1'b1;
        emit_byte = SymEsc;
      end else if (line_byte_i == SymEscEnd) begin
        do_emit   = 1'b1;
        emit_byte = SymEnd;
      end else begin
        // bad escape: drop the frame and hunt again
        in_frame_o            = 1'b0;
        byte_count_o          = '0;
        result_o.frame_abort  = 1'b1;
        result_o.frame_length = byte_count_i[FrameLenW-1:0];
      end
    end else if (line_byte_i == SymEsc) begin
      esc_pending_o         = 1'b1;
      result_o.frame_length = byte_count_i[FrameLenW-1:0];
    end else if (line_byte_i == SymEnd) begin
      byte_count_o          = '0;
      result_o.frame_length = byte_count_i[FrameLenW-1:0];
      if (byte_count_i >= CntW'(min_frame_bytes_i)) begin
        in_frame_o         = 1'b0;
        result_o.frame_end = 1'b1;
      end else begin
        result_o.frame_abort = (byte_count_i != '0);
      end
    end else begin
      do_emit = 1'b1;
    end

    if (do_emit) begin
      if (byte_count_i >= MaxCnt) begin
        // overflow: drop the byte and the frame
        in_frame_o            = 1'b0;
        esc_pending_o         = 1'b0;
        byte_count_o          = '0;
        result_o.frame_abort  = 1'b1;
        result_o.frame_length = byte_count_i[FrameLenW-1:0];
      end else begin
        byte_count_o          = cnt_inc;
        result_o.data_valid   = 1'b1;
        result_o.data_byte    = emit_byte;
        result_o.frame_length = cnt_inc[FrameLenW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

/* src/slip_stream_decoder_core.sv */
// Top level: SLIP stream decoder with input register, decode step and result register.
`default_nettype none
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one raw line byte (line_byte_i)
//   per transaction. A transaction completes at a rising edge with valid high and
//   stall low.
//   Output channel: out_valid_o / out_stall_i carry exactly one result per input
//   byte: data_valid_o/data_byte_o for a decoded payload byte, frame_end_o when a
//   closing END completes a good frame, frame_abort_o when decoded bytes are
//   discarded, and frame_length_o with the running or final count.
//   Configuration: cfg_we_i writes cfg_wdata_i into min_frame_bytes; write only
//   while no transaction is in flight.
//   Path: a byte accepted on the input channel lands in the input register, is
//   decoded by the combinational step into the result register, and leaves from
//   there as its output transaction.
//   Throughput: one byte per cycle while out_stall_i stays low; the combinational
//   decode step between the two registers sets this figure.
//   Stall: when out_stall_i holds a full result register, the input register
//   holds too and in_stall_o rises once it is occupied; no result is lost.
//   Reset: rst_ni low clears both stages, returns to hunting for END, clears the
//   count and escape flag, and sets min_frame_bytes to 2.
module slip_stream_decoder_core #(
  parameter int MAX_FRAME_BYTES = ssd_pkg::MaxFrameBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssd_pkg::FrameLenW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ssd_pkg::LineByteW-1:0] line_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          data_valid_o,
  output logic [ssd_pkg::LineByteW-1:0] data_byte_o,
  output logic                          frame_end_o,
  output logic                          frame_abort_o,
  output logic [ssd_pkg::FrameLenW-1:0] frame_length_o
);
  import ssd_pkg::*;

  localparam int CntW = cnt_width(MAX_FRAME_BYTES);
  localparam int ResW = $bits(ssd_result_t);

  logic [FrameLenW-1:0] min_frame_bytes_q;

  // decoder state
  logic            in_frame_q, in_frame_d;
  logic            esc_pending_q, esc_pending_d;
  logic [CntW-1:0] byte_count_q, byte_count_d;

  // input stage
  logic                 s1_valid;
  logic                 s1_stall;
  logic [LineByteW-1:0] s1_byte;
  logic                 s1_advance;

  // result stage
  ssd_result_t     step_res;
  ssd_result_t     out_res;
  logic [ResW-1:0] out_res_bits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_frame_bytes_q <= MinFrameBytesRst;
    end else if (cfg_we_i) begin
      min_frame_bytes_q <= cfg_wdata_i;
    end
  end

  ssd_stage #(
    .Width(LineByteW)
  ) u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .stall_o(in_stall_o),
    .data_i (line_byte_i),
    .valid_o(s1_valid),
    .stall_i(s1_stall),
    .data_o (s1_byte)
  );

  ssd_step #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .CntW           (CntW)
  ) u_step (
    .line_byte_i      (s1_byte),
    .min_frame_bytes_i(min_frame_bytes_q),
    .in_frame_i       (in_frame_q),
    .esc_pending_i    (esc_pending_q),
    .byte_count_i     (byte_count_q),
    .in_frame_o       (in_frame_d),
    .esc_pending_o    (esc_pending_d),
    .byte_count_o     (byte_count_d),
    .result_o         (step_res)
  );

  // Advance the decoder state only when the byte moves into the result register.
  assign s1_advance = s1_valid & ~s1_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      esc_pending_q <= 1'b0;
      byte_count_q  <= '0;
    end else if (s1_advance) begin
      in_frame_q    <= in_frame_d;
      esc_pending_q <= esc_pending_d;
      byte_count_q  <= byte_count_d;
    end
  end

  ssd_stage #(
    .Width(ResW)
  ) u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s1_valid),
    .stall_o(s1_stall),
    .data_i (step_res),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (out_res_bits)
  );

  assign out_res        = ssd_result_t'(out_res_bits);
  assign data_valid_o   = out_res.data_valid;
  assign data_byte_o    = out_res.data_byte;
  assign frame_end_o    = out_res.frame_end;
  assign frame_abort_o  = out_res.frame_abort;
  assign frame_length_o = out_res.frame_length;

`ifndef SYNTH
  // An escape can only be pending inside a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni) esc_pending_q |-> in_frame_q)
    else $error("escape pending while hunting");

  // The count never passes the buffer size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_count_q <= CntW'(MAX_FRAME_BYTES))
    else $error("byte count beyond buffer size");

  // A result is at most one of: payload byte, frame end, abort.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({data_valid_o, frame_end_o, frame_abort_o}))
    else $error("conflicting result flags");

  // A payload byte always comes with a nonzero running length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && data_valid_o) |-> (frame_length_o != '0))
    else $error("payload byte with zero length");

  // Hunting leaves a zero count behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (byte_count_q == '0))
    else $error("nonzero count while hunting");
`endif

endmodule
`default_nettype wire

/* sim/tb_slip_stream_decoder_core.sv */
// Testbench: drives SLIP line bytes through slip_stream_decoder_core and checks every result.
`timescale 1ns / 1ps
module tb_slip_stream_decoder_core;
  import ssd_pkg::*;

  // Cycles without any accepted transaction before the run is declared hung.
  localparam int HangLimit = 1000;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [FrameLenW-1:0] cfg_wdata   = '0;
  logic                 in_valid    = 1'b0;
  logic [LineByteW-1:0] line_byte   = '0;
  logic                 out_stall   = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 data_valid;
  logic [LineByteW-1:0] data_byte;
  logic                 frame_end;
  logic                 frame_abort;
  logic [FrameLenW-1:0] frame_length;

  // Decoder results predicted for accepted bytes, oldest first.
  ssd_result_t pending_decodes[$];

  // Shadow copy of the decoder state and the minimum frame length register.
  bit                   in_frame_q;
  bit                   esc_q;
  int unsigned          count_q;
  logic [FrameLenW-1:0] min_len_q;

  int  mismatch_cnt = 0;
  int  sent_cnt     = 0;
  int  hang_cnt     = 0;
  int  stall_left   = 0;
  // Clear to run a stretch with neither input gaps nor output stalls.
  bit  idle_en      = 1'b1;

  slip_stream_decoder_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .line_byte_i    (line_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .data_valid_o   (data_valid),
    .data_byte_o    (data_byte),
    .frame_end_o    (frame_end),
    .frame_abort_o  (frame_abort),
    .frame_length_o (frame_length)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Count one decoded byte into the frame, or drop the frame once it is full.
  function automatic ssd_result_t push_decoded(input logic [LineByteW-1:0] b);
    ssd_result_t r;
    r = '0;
    if (count_q >= MaxFrameBytesDef) begin
      r.frame_abort  = 1'b1;
      r.frame_length = FrameLenW'(count_q);
      in_frame_q     = 1'b0;
      esc_q          = 1'b0;
      count_q        = 0;
    end else begin
      count_q++;
      r.data_valid   = 1'b1;
      r.data_byte    = b;
      r.frame_length = FrameLenW'(count_q);
    end
    return r;
  endfunction

  // Advance the shadow decoder by one line byte and return its result.
  function automatic ssd_result_t decode_line_byte(input logic [LineByteW-1:0] b);
    ssd_result_t r;
    int unsigned n;
    r = '0;
    if (!in_frame_q) begin
      // Hunting: only END matters, and it opens a frame.
      if (b == SymEnd) begin
        in_frame_q = 1'b1;
        esc_q      = 1'b0;
        count_q    = 0;
      end
    end else if (esc_q) begin
      esc_q = 1'b0;
      if (b == SymEscEsc) begin
        r = push_decoded(SymEsc);
      end else if (b == SymEscEnd) begin
        r = push_decoded(SymEnd);
      end else begin
        // Bad escape: consume the byte (even END) and go back to hunting.
        r.frame_abort  = 1'b1;
        r.frame_length = FrameLenW'(count_q);
        in_frame_q     = 1'b0;
        count_q        = 0;
      end
    end else if (b == SymEsc) begin
      esc_q          = 1'b1;
      r.frame_length = FrameLenW'(count_q);
    end else if (b == SymEnd) begin
      n              = count_q;
      count_q        = 0;
      r.frame_length = FrameLenW'(n);
      if (n >= min_len_q) begin
        in_frame_q  = 1'b0;
        r.frame_end = 1'b1;
      end else begin
        // Short frame: restart the count and stay in the frame.
        r.frame_abort = (n != 0);
      end
    end else begin
      r = push_decoded(b);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  // Compare each result transaction against the oldest prediction.
  always @(posedge clk) begin : result_check
    ssd_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_decodes.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result, expected none actual len %0d", $time,
                 frame_length);
      end else begin
        want = pending_decodes.pop_front();
        check_field("data_valid", 16'(want.data_valid), 16'(data_valid));
        check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
        check_field("frame_end", 16'(want.frame_end), 16'(frame_end));
        check_field("frame_abort", 16'(want.frame_abort), 16'(frame_abort));
        check_field("frame_length", 16'(want.frame_length), 16'(frame_length));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idle patterns, output stall and watchdog
  // ---------------------------------------------------------------------------

  // Mostly short idles, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // End the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_cnt = 0;
    end else begin
      hang_cnt++;
      if (hang_cnt >= HangLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, HangLimit);
        $display("tb_slip_stream_decoder_core NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Present one line byte, hold it until accepted, then record its prediction.
  task automatic send_byte(input logic [LineByteW-1:0] b);
    int gap;
    gap = (idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    line_byte <= b;
    do @(posedge clk); while (in_stall);
    pending_decodes.push_back(decode_line_byte(b));
    sent_cnt++;
  endtask

  // Send a payload byte in its escaped line form.
  task automatic send_payload_byte(input logic [LineByteW-1:0] b);
    if (b == SymEnd) begin
      send_byte(SymEsc);
      send_byte(SymEscEnd);
    end else if (b == SymEsc) begin
      send_byte(SymEsc);
      send_byte(SymEscEsc);
    end else begin
      send_byte(b);
    end
  endtask

  // Random payload with the two framing symbols showing up often.
  function automatic logic [LineByteW-1:0] random_payload();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return SymEnd;
    if (r == 1) return SymEsc;
    return LineByteW'($urandom_range(0, 255));
  endfunction

  // Opening END, n encoded payload bytes, closing END.
  task automatic send_frame(input int n);
    send_byte(SymEnd);
    repeat (n) send_payload_byte(random_payload());
    send_byte(SymEnd);
  endtask

  // Drop valid, let every predicted result come out, then allow the pipe to settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write min_frame_bytes while the decoder is idle.
  task automatic set_min_len(input logic [FrameLenW-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    min_len_q = v;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bytes before the first END are dropped; both escapes decode inside a frame.
  task automatic test_hunting_and_escapes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SymEsc);
    send_byte(SymEscEsc);
    send_byte(SymEnd);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SymEsc);
    send_byte(SymEscEsc);
    send_byte(SymEsc);
    send_byte(SymEscEnd);
    send_byte(SymEnd);
  endtask

  // Short frames restart the count; a bad escape, END included, aborts the frame.
  task automatic test_short_frame_and_bad_escape();
    send_byte(SymEnd);
    send_byte(SymEnd);
    send_byte(8'h55);
    send_byte(SymEnd);
    send_byte(8'hAA);
    send_byte(SymEsc);
    send_byte(8'h12);
    send_byte(SymEnd);
    send_byte(SymEsc);
    send_byte(SymEnd);
  endtask

  // With a minimum of zero, END END is a complete empty frame.
  task automatic test_empty_frame_min_zero();
    set_min_len('0);
    send_byte(SymEnd);
    send_byte(SymEnd);
  endtask

  // Exact fit of a full-size frame, a minimum above the buffer, and overflow.
  task automatic test_long_frames();
    set_min_len(9'd256);
    send_frame(256);
    set_min_len(9'd257);
    send_frame(20);
    send_byte(SymEnd);
    set_min_len(9'd2);
    // Overflow on an escaped byte, then on a random payload byte.
    send_byte(SymEnd);
    repeat (256) send_byte(LineByteW'($urandom_range(0, 255)) & 8'h7F);
    send_payload_byte(SymEsc);
    send_frame(257);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames.
  task automatic test_random_traffic();
    logic [FrameLenW-1:0] mins[7] = '{9'd2, 9'd1, 9'd4, 9'd0, 9'd7, 9'd511, 9'd3};
    int                   goal;
    int                   r;
    logic [LineByteW-1:0] bad;
    foreach (mins[i]) begin
      set_min_len(mins[i]);
      goal = sent_cnt + 55;
      while (sent_cnt < goal) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          send_frame(($urandom_range(0, 99) < 85) ? $urandom_range(0, 10)
                                                  : $urandom_range(11, 40));
        end else if (r < 65) begin
          repeat ($urandom_range(1, 4)) send_byte(LineByteW'($urandom_range(0, 255)));
        end else if (r < 78) begin
          // Broken escape somewhere in a frame.
          send_byte(SymEnd);
          repeat ($urandom_range(0, 6)) send_payload_byte(random_payload());
          do bad = LineByteW'($urandom_range(0, 255));
          while (bad == SymEscEnd || bad == SymEscEsc);
          send_byte(SymEsc);
          send_byte(($urandom_range(0, 3) == 0) ? SymEnd : bad);
        end else if (r < 88) begin
          // Unterminated frame; the next END is decoded as its closing END.
          send_byte(SymEnd);
          repeat ($urandom_range(0, 5)) send_payload_byte(random_payload());
        end else if (r < 90) begin
          // Hold off the sender until every result is back.
          wait_drained();
        end else begin
          idle_en = $urandom_range(0, 2) != 0;
        end
      end
      idle_en = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_frame_q = 1'b0;
    esc_q      = 1'b0;
    count_q    = 0;
    min_len_q  = MinFrameBytesRst;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_hunting_and_escapes();
    test_short_frame_and_bad_escape();
    test_empty_frame_min_zero();
    test_long_frames();
    test_random_traffic();

    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("tb_slip_stream_decoder_core OK");
    end else begin
      $display("tb_slip_stream_decoder_core NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ssd_pkg.sv
src/ssd_stage.sv
src/ssd_step.sv
src/slip_stream_decoder_core.sv
sim/tb_slip_stream_decoder_core.sv
